// ===== hw/rtl/bracket_balance_checker_top_macros.svh =====
// assertion macros for the bracket balance checker
`ifndef BRACKET_BALANCE_CHECKER_TOP_MACROS_SVH
`define BRACKET_BALANCE_CHECKER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BBC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bbc assertion failed");
`define BBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bbc assertion failed");
`else
`define BBC_ASSERT_NOW(label, ante, cons)
`define BBC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/bbc_pkg.sv =====
// package with types and constants of the bracket balance checker
`default_nettype none
package bbc_pkg;

  localparam int BBC_STACK_DEPTH = 8192;
  localparam int BBC_ROW_LENGTH  = 8192;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ROUND  = 2'd0;
  localparam kind_t KIND_SQUARE = 2'd1;
  localparam kind_t KIND_CURLY  = 2'd2;

  typedef logic [1:0] err_t;
  localparam err_t ERR_NONE      = 2'd0;
  localparam err_t ERR_UNMATCHED = 2'd1;
  localparam err_t ERR_UNCLOSED  = 2'd2;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_BAR    = 8'h7c;
  localparam logic [7:0] CH_LROUND = 8'h28;
  localparam logic [7:0] CH_RROUND = 8'h29;
  localparam logic [7:0] CH_LSQ    = 8'h5b;
  localparam logic [7:0] CH_RSQ    = 8'h5d;
  localparam logic [7:0] CH_LCURLY = 8'h7b;
  localparam logic [7:0] CH_RCURLY = 8'h7d;

  typedef struct packed {
    logic        operation;
    logic [7:0]  symbol;
    logic        ends_row;
    logic [23:0] line_number;
  } char_t;

  typedef struct packed {
    err_t        error_kind;
    kind_t       bracket_kind;
    logic [13:0] column;
    logic [23:0] line_echo;
    logic [13:0] nesting_depth;
  } report_t;

  typedef struct packed {
    logic  push;
    logic  pop;
    logic  clear;
    kind_t kind;
  } stack_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bbc_stack.sv =====
// bracket stack: memory for buried entries, top register, forwarded second entry
`default_nettype none
module bbc_stack import bbc_pkg::*; #(
  parameter int  STACK_DEPTH = BBC_STACK_DEPTH,
  localparam int DW = $clog2(STACK_DEPTH + 1),
  localparam int AW = $clog2(STACK_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  stack_cmd_t    cmd,
  output kind_t         top_kind,
  output logic [DW-1:0] depth,
  output logic [DW-1:0] depth_next
);

  kind_t         mem [STACK_DEPTH];
  kind_t         rdata;
  kind_t         top;
  kind_t         fwd_kind;
  kind_t         below;
  logic          fwd;
  logic          do_push;
  logic          do_pop;
  logic          mem_we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  assign do_push = cmd.push && !cmd.clear && (depth != DW'(STACK_DEPTH));
  assign do_pop  = cmd.pop && !cmd.clear && (depth != '0);
  assign mem_we  = do_push && (depth != '0);
  assign waddr   = AW'(depth - DW'(1));
  assign raddr   = AW'(depth_next - DW'(2));
  assign below   = fwd ? fwd_kind : rdata;
  assign top_kind = top;

  always_comb begin
    depth_next = depth;
    if (cmd.clear) begin
      depth_next = '0;
    end else if (do_push) begin
      depth_next = depth + DW'(1);
    end else if (do_pop) begin
      depth_next = depth - DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= top;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
      fwd   <= 1'b0;
    end else begin
      depth <= depth_next;
      fwd   <= mem_we;
    end
  end

  always_ff @(posedge clk) begin
    fwd_kind <= top;
    if (do_push) begin
      top <= cmd.kind;
    end else if (do_pop) begin
      top <= below;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bracket_balance_checker_top.sv =====
// top level of the bracket balance checker
`default_nettype none
// Takes one character per cycle while char_stall is low and returns one report per
// character, registered; a two-entry output buffer keeps the input flowing while
// its skid entry is free after the output stalls. The open-bracket stack lives in a
// memory with one write and one registered read per cycle; the top entry sits in a
// register and the entry below it is read ahead, forwarded when it was just
// written, so push and pop sustain one character per cycle. No clearing pass
// after reset; an end-of-input item clears the stack and the row state.
module bracket_balance_checker_top import bbc_pkg::*; #(
  parameter int  STACK_DEPTH = BBC_STACK_DEPTH,
  parameter int  ROW_LENGTH  = BBC_ROW_LENGTH,
  localparam int DW = $clog2(STACK_DEPTH + 1),
  localparam int CW = $clog2(ROW_LENGTH + 1)
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    char_valid,
  output logic    char_stall,
  input  char_t   char_data,
  output logic    report_valid,
  input  logic    report_stall,
  output report_t report_data
);

  logic          accept;
  logic          is_end;
  logic [7:0]    c;
  stack_cmd_t    cmd;
  kind_t         top_kind;
  logic [DW-1:0] depth;
  logic [DW-1:0] depth_next;

  logic [CW-1:0] row_column;
  logic [CW-1:0] row_column_next;
  logic [CW-1:0] col;
  logic          in_quote;
  logic          in_quote_next;
  logic          quote_is_double;
  logic          quote_is_double_next;
  logic          skip_next;
  logic          skip_next_next;
  logic          rest_is_comment;
  logic          rest_is_comment_next;

  logic          is_open;
  logic          is_close;
  kind_t         sym_kind;
  report_t       result;

  logic          skid_valid;
  report_t       skid;
  logic          out_free;

  bbc_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .top_kind   (top_kind),
    .depth      (depth),
    .depth_next (depth_next)
  );

  assign char_stall = skid_valid;
  assign accept     = char_valid && !char_stall;
  assign is_end     = (char_data.operation == OP_END);
  assign c          = char_data.symbol;
  assign col        = (row_column >= CW'(ROW_LENGTH)) ? CW'(ROW_LENGTH)
                                                      : row_column + CW'(1);
  assign is_open    = (c == CH_LROUND) || (c == CH_LSQ) || (c == CH_LCURLY);
  assign is_close   = (c == CH_RROUND) || (c == CH_RSQ) || (c == CH_RCURLY);

  always_comb begin
    unique case (c)
      CH_LSQ, CH_RSQ:       sym_kind = KIND_SQUARE;
      CH_LCURLY, CH_RCURLY: sym_kind = KIND_CURLY;
      default:              sym_kind = KIND_ROUND;
    endcase
  end

  always_comb begin
    row_column_next      = row_column;
    in_quote_next        = in_quote;
    quote_is_double_next = quote_is_double;
    skip_next_next       = skip_next;
    rest_is_comment_next = rest_is_comment;
    cmd                  = '0;
    cmd.kind             = sym_kind;
    result               = '0;
    result.line_echo     = char_data.line_number;
    if (is_end) begin
      if (depth != '0) begin
        result.error_kind   = ERR_UNCLOSED;
        result.bracket_kind = top_kind;
      end
      cmd.clear            = accept;
      row_column_next      = '0;
      in_quote_next        = 1'b0;
      quote_is_double_next = 1'b0;
      skip_next_next       = 1'b0;
      rest_is_comment_next = 1'b0;
    end else begin
      row_column_next = col;
      result.column   = 14'(col);
      if (rest_is_comment) begin
        rest_is_comment_next = 1'b1;
      end else if (skip_next) begin
        skip_next_next = 1'b0;
      end else if (c == CH_NUL || c == CH_LF) begin
        rest_is_comment_next = 1'b1;
      end else if (in_quote) begin
        if (c == CH_BSLASH) begin
          skip_next_next = 1'b1;
        end else if (c == (quote_is_double ? CH_DQUOTE : CH_SQUOTE)) begin
          in_quote_next = 1'b0;
        end
      end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
        in_quote_next        = 1'b1;
        quote_is_double_next = (c == CH_DQUOTE);
      end else if (c == CH_BAR) begin
        rest_is_comment_next = 1'b1;
      end else if (is_open) begin
        cmd.push = accept;
      end else if (is_close) begin
        if (depth == '0 || top_kind != sym_kind) begin
          result.error_kind   = ERR_UNMATCHED;
          result.bracket_kind = sym_kind;
        end else begin
          cmd.pop = accept;
        end
      end
      if (char_data.ends_row) begin
        row_column_next      = '0;
        in_quote_next        = 1'b0;
        quote_is_double_next = 1'b0;
        skip_next_next       = 1'b0;
        rest_is_comment_next = 1'b0;
      end
    end
    result.nesting_depth = 14'(depth_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_column      <= '0;
      in_quote        <= 1'b0;
      quote_is_double <= 1'b0;
      skip_next       <= 1'b0;
      rest_is_comment <= 1'b0;
    end else if (accept) begin
      row_column      <= row_column_next;
      in_quote        <= in_quote_next;
      quote_is_double <= quote_is_double_next;
      skip_next       <= skip_next_next;
      rest_is_comment <= rest_is_comment_next;
    end
  end

  // output register with one skid entry
  assign out_free = !report_valid || !report_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (out_free) begin
        report_valid <= accept || skid_valid;
        skid_valid   <= 1'b0;
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      report_data <= skid_valid ? skid : result;
    end
    if (accept && !out_free) begin
      skid <= result;
    end
  end

  `include "bracket_balance_checker_top_macros.svh"

  `BBC_ASSERT_NOW(a_skid_behind_out, skid_valid, report_valid)
  `BBC_ASSERT_NEXT(a_end_clears, accept && is_end, depth == '0 && row_column == '0)
  `BBC_ASSERT_NEXT(a_push_grows, cmd.push && depth != DW'(STACK_DEPTH), depth == $past(depth) + DW'(1))
  `BBC_ASSERT_NOW(a_kind_legal, report_valid, report_data.bracket_kind != 2'd3)

endmodule
`default_nettype wire

// ===== sim/tb_bracket_balance_checker_top.sv =====
`timescale 1ns / 1ps
// testbench of the bracket balance checker: directed rows, one deep row and random rows
module tb_bracket_balance_checker_top;
  import bbc_pkg::*;

  localparam int QUIET_LIMIT    = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_ITEMS   = 640;
  localparam int LONG_ROW_ITEMS = 40;

  typedef struct {
    char_t   item;
    bit      typed;
    report_t want;
  } vector_t;

  logic    clk;
  logic    rst;
  logic    char_valid;
  logic    char_stall;
  char_t   char_data;
  logic    report_valid;
  logic    report_stall;
  report_t report_data;

  bit      fixed_on;
  report_t fixed_want;
  bit      gaps_on;
  bit      hold_req;
  report_t due_reports[$];
  int      mismatches = 0;
  int      quiet_cycles = 0;

  // bracket state as the block should hold it
  kind_t open_kinds [BBC_STACK_DEPTH];
  int    open_count = 0;
  int    row_col = 0;
  bit    quoted = 1'b0;
  bit    dbl_quote = 1'b0;
  bit    escaped = 1'b0;
  bit    row_done = 1'b0;

  bracket_balance_checker_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_data    (char_data),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .report_data  (report_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void clear_row();
    row_col   = 0;
    quoted    = 1'b0;
    dbl_quote = 1'b0;
    escaped   = 1'b0;
    row_done  = 1'b0;
  endfunction

  function automatic report_t bracket_step(input char_t c);
    report_t r;
    kind_t   k;
    r = '0;
    r.line_echo = c.line_number;
    if (c.operation == OP_END) begin
      if (open_count > 0) begin
        r.error_kind   = ERR_UNCLOSED;
        r.bracket_kind = open_kinds[open_count - 1];
      end
      open_count = 0;
      clear_row();
      return r;
    end
    row_col = (row_col < BBC_ROW_LENGTH) ? row_col + 1 : BBC_ROW_LENGTH;
    if (!row_done) begin
      if (escaped) begin
        escaped = 1'b0;
      end else if (c.symbol == CH_NUL || c.symbol == CH_LF) begin
        row_done = 1'b1;
      end else if (quoted) begin
        if (c.symbol == CH_BSLASH) begin
          escaped = 1'b1;
        end else if (c.symbol == (dbl_quote ? CH_DQUOTE : CH_SQUOTE)) begin
          quoted = 1'b0;
        end
      end else if (c.symbol == CH_SQUOTE || c.symbol == CH_DQUOTE) begin
        quoted    = 1'b1;
        dbl_quote = (c.symbol == CH_DQUOTE);
      end else if (c.symbol == CH_BAR) begin
        row_done = 1'b1;
      end else begin
        case (c.symbol)
          CH_LROUND, CH_LSQ, CH_LCURLY: begin
            k = (c.symbol == CH_LROUND) ? KIND_ROUND :
                (c.symbol == CH_LSQ) ? KIND_SQUARE : KIND_CURLY;
            if (open_count < BBC_STACK_DEPTH) begin
              open_kinds[open_count] = k;
              open_count++;
            end
          end
          CH_RROUND, CH_RSQ, CH_RCURLY: begin
            k = (c.symbol == CH_RROUND) ? KIND_ROUND :
                (c.symbol == CH_RSQ) ? KIND_SQUARE : KIND_CURLY;
            if (open_count == 0 || open_kinds[open_count - 1] != k) begin
              r.error_kind   = ERR_UNMATCHED;
              r.bracket_kind = k;
            end else begin
              open_count--;
            end
          end
          default: begin
          end
        endcase
      end
    end
    r.column        = 14'(row_col);
    r.nesting_depth = 14'(open_count);
    if (c.ends_row) clear_row();
    return r;
  endfunction

  // mostly brackets, closes usually match the current top
  function automatic logic [7:0] pick_symbol();
    int unsigned roll;
    kind_t       k;
    roll = $urandom_range(0, 99);
    k = kind_t'($urandom_range(0, 2));
    if (roll >= 25 && roll < 50 && open_count > 0 && $urandom_range(0, 99) < 85)
      k = open_kinds[open_count - 1];
    if (roll < 25) return (k == KIND_ROUND) ? CH_LROUND : (k == KIND_SQUARE) ? CH_LSQ : CH_LCURLY;
    if (roll < 50) return (k == KIND_ROUND) ? CH_RROUND : (k == KIND_SQUARE) ? CH_RSQ : CH_RCURLY;
    if (roll < 54) return CH_SQUOTE;
    if (roll < 58) return CH_DQUOTE;
    if (roll < 62) return CH_BSLASH;
    if (roll < 65) return CH_BAR;
    if (roll < 67) return CH_LF;
    if (roll < 68) return CH_NUL;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic offer(input char_t item, input bit typed, input report_t want);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      char_valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    char_valid = 1'b1;
    char_data  = item;
    fixed_on   = typed;
    fixed_want = want;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    char_valid = 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver side: short stall bursts, one long hold-off on request
  initial begin
    report_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        report_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        report_stall = 1'b0;
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        report_stall = 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        report_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_proc
    report_t want;
    bit      took;
    took = 1'b0;
    if (!rst) begin
      if (char_valid && !char_stall) begin
        want = bracket_step(char_data);
        if (fixed_on) want = fixed_want;
        due_reports.push_back(want);
        took = 1'b1;
      end
      if (report_valid && !report_stall) begin
        took = 1'b1;
        if (due_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transfer: err=%0d kind=%0d col=%0d line=%0d depth=%0d",
                     report_data.error_kind, report_data.bracket_kind, report_data.column,
                     report_data.line_echo, report_data.nesting_depth);
        end else begin
          want = due_reports.pop_front();
          if (report_data.error_kind !== want.error_kind ||
              report_data.bracket_kind !== want.bracket_kind ||
              report_data.column !== want.column ||
              report_data.line_echo !== want.line_echo ||
              report_data.nesting_depth !== want.nesting_depth) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp err=%0d kind=%0d col=%0d line=%0d depth=%0d,",
                        " got err=%0d kind=%0d col=%0d line=%0d depth=%0d"},
                       want.error_kind, want.bracket_kind, want.column, want.line_echo,
                       want.nesting_depth, report_data.error_kind, report_data.bracket_kind,
                       report_data.column, report_data.line_echo, report_data.nesting_depth);
          end
        end
      end
      quiet_cycles = took ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("bracket_balance_checker_top verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    vector_t     directed_rows[$];
    int unsigned row_line;
    int unsigned row_len;
    int          sent;
    bit          held;
    bit          paused;
    rst        = 1'b1;
    char_valid = 1'b0;
    char_data  = '0;
    fixed_on   = 1'b0;
    fixed_want = '0;
    gaps_on    = 1'b0;
    hold_req   = 1'b0;
    held       = 1'b0;
    paused     = 1'b0;

    directed_rows.push_back('{'{OP_END, CH_NUL, 1'b0, 24'd1}, 1'b1,
                              '{ERR_NONE, KIND_ROUND, 14'd0, 24'd1, 14'd0}});
    directed_rows.push_back('{'{OP_CHAR, CH_LROUND, 1'b0, 24'd2}, 1'b0, '0});
    directed_rows.push_back('{'{OP_CHAR, CH_LSQ, 1'b0, 24'd2}, 1'b0, '0});
    directed_rows.push_back('{'{OP_CHAR, CH_LCURLY, 1'b0, 24'd2}, 1'b0, '0});
    directed_rows.push_back('{'{OP_CHAR, CH_RROUND, 1'b0, 24'd2}, 1'b1,
                              '{ERR_UNMATCHED, KIND_ROUND, 14'd4, 24'd2, 14'd3}});
    directed_rows.push_back('{'{OP_CHAR, CH_RCURLY, 1'b0, 24'd2}, 1'b0, '0});
    directed_rows.push_back('{'{OP_CHAR, CH_DQUOTE, 1'b0, 24'd2}, 1'b0, '0});
    directed_rows.push_back('{'{OP_CHAR, CH_RROUND, 1'b0, 24'd2}, 1'b0, '0});
    directed_rows.push_back('{'{OP_CHAR, CH_SQUOTE, 1'b0, 24'd2}, 1'b0, '0});
    directed_rows.push_back('{'{OP_CHAR, CH_BSLASH, 1'b0, 24'd2}, 1'b0, '0});
    directed_rows.push_back('{'{OP_CHAR, CH_DQUOTE, 1'b0, 24'd2}, 1'b0, '0});
    directed_rows.push_back('{'{OP_CHAR, CH_DQUOTE, 1'b0, 24'd2}, 1'b0, '0});
    directed_rows.push_back('{'{OP_CHAR, CH_SQUOTE, 1'b0, 24'd2}, 1'b0, '0});
    directed_rows.push_back('{'{OP_CHAR, CH_BSLASH, 1'b0, 24'd2}, 1'b0, '0});
    directed_rows.push_back('{'{OP_CHAR, CH_LF, 1'b0, 24'd2}, 1'b0, '0});
    directed_rows.push_back('{'{OP_CHAR, CH_LF, 1'b0, 24'd2}, 1'b0, '0});
    directed_rows.push_back('{'{OP_CHAR, CH_RSQ, 1'b1, 24'd2}, 1'b0, '0});
    // escape as the last character of a row
    directed_rows.push_back('{'{OP_CHAR, CH_SQUOTE, 1'b0, 24'd3}, 1'b0, '0});
    directed_rows.push_back('{'{OP_CHAR, CH_BSLASH, 1'b1, 24'd3}, 1'b0, '0});
    directed_rows.push_back('{'{OP_CHAR, CH_RSQ, 1'b0, 24'd4}, 1'b0, '0});
    directed_rows.push_back('{'{OP_CHAR, CH_BAR, 1'b0, 24'd4}, 1'b0, '0});
    directed_rows.push_back('{'{OP_CHAR, CH_RROUND, 1'b0, 24'd4}, 1'b0, '0});
    directed_rows.push_back('{'{OP_CHAR, 8'hff, 1'b1, 24'd4}, 1'b0, '0});
    directed_rows.push_back('{'{OP_CHAR, CH_NUL, 1'b0, 24'd5}, 1'b0, '0});
    directed_rows.push_back('{'{OP_CHAR, CH_LROUND, 1'b1, 24'd5}, 1'b0, '0});
    directed_rows.push_back('{'{OP_CHAR, CH_RROUND, 1'b0, 24'd6}, 1'b0, '0});
    directed_rows.push_back('{'{OP_CHAR, CH_RROUND, 1'b1, 24'd6}, 1'b1,
                              '{ERR_UNMATCHED, KIND_ROUND, 14'd2, 24'd6, 14'd0}});
    directed_rows.push_back('{'{OP_CHAR, CH_LCURLY, 1'b0, 24'hffffff}, 1'b0, '0});
    directed_rows.push_back('{'{OP_END, 8'hff, 1'b1, 24'hffffff}, 1'b1,
                              '{ERR_UNCLOSED, KIND_CURLY, 14'd0, 24'hffffff, 14'd0}});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    drain();

    // one deep row of opens back to back, then closes against the stack
    for (int i = 0; i < LONG_ROW_ITEMS; i++)
      offer('{OP_CHAR, CH_LROUND, 1'b0, 24'd100}, 1'b0, '0);
    offer('{OP_CHAR, CH_RSQ, 1'b0, 24'd100}, 1'b0, '0);
    offer('{OP_CHAR, CH_RROUND, 1'b0, 24'd100}, 1'b0, '0);
    offer('{OP_CHAR, CH_LSQ, 1'b1, 24'd100}, 1'b0, '0);
    offer('{OP_END, CH_NUL, 1'b0, 24'd101}, 1'b0, '0);
    drain();

    sent = 0;
    row_line = 200;
    while (sent < RANDOM_ITEMS) begin
      gaps_on = (sent < RANDOM_ITEMS - 100) && ($urandom_range(0, 2) != 0);
      if (sent >= 150 && !held) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      if (sent >= 400 && !paused) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(0, 7) == 0) begin
        offer('{OP_END, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                24'($urandom)}, 1'b0, '0);
        sent++;
      end else begin
        row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
        row_line = ($urandom_range(0, 3) == 0) ? 24'($urandom) : row_line + 1;
        for (int i = 0; i < row_len; i++) begin
          offer('{OP_CHAR, pick_symbol(),
                  (i == row_len - 1) ? 1'($urandom_range(0, 9) != 0) : 1'b0,
                  24'(row_line)}, 1'b0, '0);
          sent++;
        end
      end
    end
    gaps_on = 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && due_reports.size() == 0) begin
      $display("bracket_balance_checker_top verification clean");
    end else begin
      $display("bracket_balance_checker_top verification failed");
    end
    $finish;
  end

endmodule
